// File: rtl/uer_pkg.sv
// Package for the ultrasonic echo ranger: widths, register indexes, reset values
// and the payload and status types shared by the ranger modules.
// No dependencies.
`default_nettype none

package uer_pkg;

  localparam int unsigned COUNT_WIDTH_DEF    = 16;
  localparam int unsigned TICKS_PER_UNIT_DEF = 29;

  localparam int unsigned HOLDOFF_W = 16;
  localparam int unsigned TICKS_W   = 8;
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd2;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST  = 16'd100;
  localparam logic [TICKS_W-1:0]   TICKS_RST    = 8'd5;
  localparam logic [DIST_W-1:0]    MAX_DIST_RST = 12'd300;
  localparam logic [MS_W-1:0]      MS_MAX       = 16'hFFFF;

  typedef struct packed {
    logic echo;
    logic ms_tick;
    logic trig_request;
  } in_item_t;

  typedef struct packed {
    logic              trig;
    logic [DIST_W-1:0] distance;
    logic              done_res;
    logic              new_result;
  } out_item_t;

  typedef struct packed {
    logic              fresh;
    logic [DIST_W-1:0] distance;
  } meas_stat_t;

endpackage

`default_nettype wire

// File: rtl/uer_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
// Payload type is a parameter; used with the types of uer_pkg.
`default_nettype none

interface uer_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger_core.sv
// Top level of the ultrasonic echo ranger: input register, configuration
// registers, result register. Depends on uer_pkg, uer_chan_if, uer_meas, uer_trig.
`default_nettype none

// One transaction on in_i is one count-clock tick and yields exactly one result
// transaction on out_o, via the input and result registers. While out_o is not
// stalled a new tick is taken every cycle: the input register feeds a single pass
// of logic (edge detect, counter, one reciprocal multiply for the divide, clamp,
// trigger timer) into the result register, for one tick per cycle sustained.
// Configuration writes take effect on the next cycle and belong to idle times.
module ultrasonic_echo_ranger_core #(
  parameter int unsigned COUNT_WIDTH    = uer_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICKS_PER_UNIT = uer_pkg::TICKS_PER_UNIT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  uer_chan_if.sink                            in_i,
  uer_chan_if.source                          out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [uer_pkg::HOLDOFF_W-1:0] holdoff_q;
  logic [uer_pkg::TICKS_W-1:0]   ticks_q;
  logic [uer_pkg::DIST_W-1:0]    max_dist_q;

  logic                 s1_valid_q;
  uer_pkg::in_item_t    s1_data_q;
  logic                 out_valid_q;
  uer_pkg::out_item_t   out_data_q;
  uer_pkg::out_item_t   res;
  uer_pkg::meas_stat_t  stat;
  logic                 out_free;
  logic                 fire;
  logic                 trig;
  logic                 done;

  assign out_free = ~out_valid_q | out_o.ready;
  assign fire     = s1_valid_q & out_free;
  assign in_i.ready = ~s1_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q  <= uer_pkg::HOLDOFF_RST;
      ticks_q    <= uer_pkg::TICKS_RST;
      max_dist_q <= uer_pkg::MAX_DIST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uer_pkg::REG_HOLDOFF_MS: holdoff_q <= cfg_data_i[uer_pkg::HOLDOFF_W-1:0];
        uer_pkg::REG_TRIG_TICKS: ticks_q <= cfg_data_i[uer_pkg::TICKS_W-1:0];
        uer_pkg::REG_MAX_DISTANCE: max_dist_q <= cfg_data_i[uer_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.payload;
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  uer_meas #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .TICKS_PER_UNIT (TICKS_PER_UNIT)
  ) u_meas (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .echo_i         (s1_data_q.echo),
    .max_distance_i (max_dist_q),
    .stat_o         (stat)
  );

  uer_trig u_trig (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .ms_tick_i      (s1_data_q.ms_tick),
    .trig_request_i (s1_data_q.trig_request),
    .holdoff_ms_i   (holdoff_q),
    .trig_ticks_i   (ticks_q),
    .stat_i         (stat),
    .trig_o         (trig),
    .done_o         (done)
  );

  assign res.trig       = trig;
  assign res.distance   = stat.distance;
  assign res.done_res   = done;
  assign res.new_result = stat.fresh;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> in_i.ready)
    else $error("input stalled while result register is free");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("pending tick lost while output stalled");

  a_fire_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed tick produced no result");

endmodule

`default_nettype wire

// File: rtl/uer_meas.sv
// Echo pulse measurement: edge detect, wrapping tick counter, reciprocal divide
// by the ticks-per-unit constant and clamp. Depends on uer_pkg.
`default_nettype none

module uer_meas #(
  parameter int unsigned COUNT_WIDTH    = uer_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICKS_PER_UNIT = uer_pkg::TICKS_PER_UNIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          echo_i,
  input  wire logic [uer_pkg::DIST_W-1:0]    max_distance_i,
  output uer_pkg::meas_stat_t                stat_o
);

  localparam int unsigned SHIFT_L = $clog2(TICKS_PER_UNIT);
  localparam int unsigned SH      = COUNT_WIDTH + SHIFT_L;
  localparam int unsigned PW      = SH + COUNT_WIDTH;
  localparam logic [63:0] RECIP   =
    ((64'd1 << SH) + 64'(TICKS_PER_UNIT) - 64'd1) / 64'(TICKS_PER_UNIT);
  localparam int unsigned CMP_W   =
    (COUNT_WIDTH > uer_pkg::DIST_W) ? COUNT_WIDTH : uer_pkg::DIST_W;

  logic                          prev_q;
  logic                          meas_q;
  logic [COUNT_WIDTH-1:0]        cnt_q;
  logic [uer_pkg::DIST_W-1:0]    dist_q, dist_d;
  logic                          rise;
  logic                          fall;
  logic [COUNT_WIDTH-1:0]        cnt_inc;
  logic [PW-1:0]                 prod;
  logic [COUNT_WIDTH-1:0]        quot;
  logic [CMP_W-1:0]              quot_x;
  logic [CMP_W-1:0]              max_x;

  assign rise    = echo_i & ~prev_q;
  assign fall    = ~rise & meas_q & ~echo_i & prev_q;
  assign cnt_inc = cnt_q + COUNT_WIDTH'(1);
  assign prod    = PW'(cnt_inc) * PW'(RECIP[COUNT_WIDTH:0]);
  assign quot    = prod[SH +: COUNT_WIDTH];
  assign quot_x  = CMP_W'(quot);
  assign max_x   = CMP_W'(max_distance_i);

  always_comb begin
    dist_d = dist_q;
    if (fall) begin
      if (quot_x > max_x) begin
        dist_d = max_distance_i;
      end else begin
        dist_d = quot_x[uer_pkg::DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      meas_q <= 1'b0;
      cnt_q  <= '0;
      dist_q <= '0;
    end else if (step_i) begin
      prev_q <= echo_i;
      dist_q <= dist_d;
      if (rise) begin
        cnt_q  <= '0;
        meas_q <= 1'b1;
      end else if (meas_q) begin
        cnt_q <= cnt_inc;
        if (fall) begin
          meas_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.fresh    = fall;
  assign stat_o.distance = dist_d;

endmodule

`default_nettype wire

// File: rtl/uer_trig.sv
// Trigger pulse generator, saturating millisecond count and done flag.
// Depends on uer_pkg.
`default_nettype none

module uer_trig (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          ms_tick_i,
  input  wire logic                          trig_request_i,
  input  wire logic [uer_pkg::HOLDOFF_W-1:0] holdoff_ms_i,
  input  wire logic [uer_pkg::TICKS_W-1:0]   trig_ticks_i,
  input  wire uer_pkg::meas_stat_t           stat_i,
  output logic                               trig_o,
  output logic                               done_o
);

  logic [uer_pkg::MS_W-1:0]    ms_q, ms_d;
  logic [uer_pkg::TICKS_W-1:0] left_q, left_d, left_now;
  logic                        done_q, done_d;
  logic                        start;

  assign start = trig_request_i & done_q & (left_q == '0) &
                 (ms_q > uer_pkg::MS_W'(holdoff_ms_i));

  always_comb begin
    ms_d     = ms_q;
    left_now = left_q;
    done_d   = done_q;
    if (stat_i.fresh) begin
      done_d = 1'b1;
    end
    if (start) begin
      ms_d     = '0;
      done_d   = 1'b0;
      left_now = (trig_ticks_i == '0) ? uer_pkg::TICKS_W'(1) : trig_ticks_i;
    end else if (ms_tick_i && (ms_q != uer_pkg::MS_MAX)) begin
      ms_d = ms_q + uer_pkg::MS_W'(1);
    end
    left_d = (left_now != '0) ? left_now - uer_pkg::TICKS_W'(1) : left_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q   <= '0;
      left_q <= '0;
      done_q <= 1'b1;
    end else if (step_i) begin
      ms_q   <= ms_d;
      left_q <= left_d;
      done_q <= done_d;
    end
  end

  assign trig_o = (left_now != '0);
  assign done_o = done_d;

endmodule

`default_nettype wire
